@@ design/gcmb_pkg.sv @@
// gcmb_pkg: shared constants, codes and control/status types of the mark map scanner
// used by every module of the block; depends on nothing

package gcmb_pkg;

   localparam int BLOCK_BYTES = 4096;
   localparam int MAX_UNITS   = 256;
   localparam int MIN_UNIT    = 16;
   localparam int MAX_UNIT    = 4096;

   localparam int SIZE_W  = 13;  // unit size register
   localparam int OFF_W   = 12;  // byte offset
   localparam int IDX_W   = 8;   // reported unit index
   localparam int POS_W   = 9;   // unit count, iterator, free counter
   localparam int OP_W    = 3;

   localparam int ROW_BITS = 8;
   localparam int ROWS     = MAX_UNITS / ROW_BITS;
   localparam int ROW_AW   = $clog2(ROWS);
   localparam int BIT_AW   = $clog2(ROW_BITS);

   localparam int DIV_W     = SIZE_W;            // dividend and divisor
   localparam int QUO_W     = POS_W;             // quotient
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int DSH_W     = DIV_W + QUO_W - 1;

   localparam int FREE_MAX = 511;

   typedef enum logic [OP_W-1:0] {
      OP_MARK_BLACK = 3'd0,
      OP_MARK_WHITE = 3'd1,
      OP_ALL_WHITE  = 3'd2,
      OP_ARRANGE    = 3'd3,
      OP_FREE_MARK  = 3'd4,
      OP_ITER_FIRST = 3'd5,
      OP_ITER_NEXT  = 3'd6
   } gcmb_op_type;

   // microprogram addresses
   typedef enum logic [3:0] {
      S_IDLE   = 4'd0,
      S_DIV    = 4'd1,
      S_BRANCH = 4'd2,
      S_DISP   = 4'd3,
      S_CSET   = 4'd4,
      S_MRD    = 4'd5,
      S_MWR    = 4'd6,
      S_WHITE  = 4'd7,
      S_BLACK  = 4'd8,
      S_FIRST  = 4'd9,
      S_NEXT   = 4'd10,
      S_SRD    = 4'd11,
      S_SCHK   = 4'd12,
      S_SNONE  = 4'd13,
      S_OUT    = 4'd14
   } gcmb_step_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_START,
      COND_DIV_LAST,
      COND_CFG_RUN,
      COND_DISPATCH,
      COND_IDX_ERR,
      COND_ITER_END,
      COND_SCAN_PAST,
      COND_FOUND,
      COND_RSP_BLOCKED
   } gcmb_cond_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_IDLE,
      ACT_DIV_STEP,
      ACT_UNIT_SET,
      ACT_MARK_RD,
      ACT_MARK_WR,
      ACT_ALL_WHITE,
      ACT_ALL_BLACK,
      ACT_SCAN_FIRST,
      ACT_SCAN_NEXT,
      ACT_SCAN_RD,
      ACT_SCAN_CHK,
      ACT_SCAN_NONE,
      ACT_OUT
   } gcmb_act_type;

   typedef struct packed {
      gcmb_act_type  act;
      gcmb_cond_type cond;
      gcmb_step_type jt;
      gcmb_step_type jf;
   } gcmb_ctrl_type;

   typedef struct packed {
      logic            start;
      logic            div_last;
      logic            cfg_run;
      logic            idx_err;
      logic            iter_end;
      logic            scan_past;
      logic            found;
      logic            rsp_blocked;
      logic [OP_W-1:0] opcode;
   } gcmb_stat_type;

endpackage

@@ design/gcmb_divider.sv @@
// gcmb_divider: restoring divider, one quotient bit per step
// depends on gcmb_pkg

module gcmb_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          step,
   input  logic [gcmb_pkg::DIV_W-1:0]    dividend,
   input  logic [gcmb_pkg::DIV_W-1:0]    divisor,
   output logic [gcmb_pkg::QUO_W-1:0]    quotient,
   output logic                          last
);

   logic [gcmb_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [gcmb_pkg::DSH_W-1:0] dsh_ff, dsh_in;
   logic [gcmb_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [gcmb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [gcmb_pkg::DSH_W-1:0] rem_wide;

   assign rem_wide = {{(gcmb_pkg::DSH_W - gcmb_pkg::DIV_W){1'b0}}, rem_ff};

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = dividend;
         dsh_in = {divisor, {(gcmb_pkg::QUO_W - 1){1'b0}}};
         quo_in = '0;
         cnt_in = gcmb_pkg::CNT_W'(gcmb_pkg::DIV_STEPS);
      end else if (step && (cnt_ff != '0)) begin
         if (rem_wide >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff[gcmb_pkg::DIV_W-1:0];
            quo_in = {quo_ff[gcmb_pkg::QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[gcmb_pkg::QUO_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - gcmb_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign quotient = quo_ff;
   assign last     = (cnt_ff == gcmb_pkg::CNT_W'(1));

endmodule

@@ design/gcmb_mark_map.sv @@
// gcmb_mark_map: mark bits held as rows of a small memory, with per-row valid bits
// and a fill colour, so whole-map clears need no row writes; depends on gcmb_pkg

module gcmb_mark_map (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clr_en,
   input  logic                             clr_val,
   input  logic                             rd_en,
   input  logic [gcmb_pkg::ROW_AW-1:0]      rd_row,
   input  logic                             wr_en,
   input  logic [gcmb_pkg::ROW_AW-1:0]      wr_row,
   input  logic [gcmb_pkg::ROW_BITS-1:0]    wr_data,
   output logic [gcmb_pkg::ROW_BITS-1:0]    row_data
);

   logic [gcmb_pkg::ROW_BITS-1:0] mem [gcmb_pkg::ROWS];
   logic [gcmb_pkg::ROW_BITS-1:0] rdata_ff;
   logic [gcmb_pkg::ROW_AW-1:0]   rrow_ff;
   logic [gcmb_pkg::ROWS-1:0]     valid_ff, valid_in;
   logic                          fill_ff, fill_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_row];
         rrow_ff  <= rd_row;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      if (clr_en) begin
         valid_in = '0;
         fill_in  = clr_val;
      end else if (wr_en) begin
         valid_in[wr_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   // rows never written since the last clear read as the fill colour
   assign row_data = valid_ff[rrow_ff] ? rdata_ff : {gcmb_pkg::ROW_BITS{fill_ff}};

endmodule

@@ design/gcmb_sequencer.sv @@
// gcmb_sequencer: step counter and microprogram rom with conditional jumps
// depends on gcmb_pkg

module gcmb_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  gcmb_pkg::gcmb_stat_type  stat,
   output gcmb_pkg::gcmb_ctrl_type  ctrl
);

   gcmb_pkg::gcmb_step_type pc_ff, pc_in;
   logic                    take;

   function automatic gcmb_pkg::gcmb_ctrl_type rom(input gcmb_pkg::gcmb_step_type pc);
      gcmb_pkg::gcmb_ctrl_type w;
      w = '{gcmb_pkg::ACT_NONE, gcmb_pkg::COND_ALWAYS, gcmb_pkg::S_IDLE, gcmb_pkg::S_IDLE};
      case (pc)
         gcmb_pkg::S_IDLE:   w = '{gcmb_pkg::ACT_IDLE, gcmb_pkg::COND_START,
                                   gcmb_pkg::S_DIV, gcmb_pkg::S_IDLE};
         gcmb_pkg::S_DIV:    w = '{gcmb_pkg::ACT_DIV_STEP, gcmb_pkg::COND_DIV_LAST,
                                   gcmb_pkg::S_BRANCH, gcmb_pkg::S_DIV};
         gcmb_pkg::S_BRANCH: w = '{gcmb_pkg::ACT_NONE, gcmb_pkg::COND_CFG_RUN,
                                   gcmb_pkg::S_CSET, gcmb_pkg::S_DISP};
         gcmb_pkg::S_DISP:   w = '{gcmb_pkg::ACT_NONE, gcmb_pkg::COND_DISPATCH,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_OUT};
         gcmb_pkg::S_CSET:   w = '{gcmb_pkg::ACT_UNIT_SET, gcmb_pkg::COND_ALWAYS,
                                   gcmb_pkg::S_IDLE, gcmb_pkg::S_IDLE};
         gcmb_pkg::S_MRD:    w = '{gcmb_pkg::ACT_MARK_RD, gcmb_pkg::COND_IDX_ERR,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_MWR};
         gcmb_pkg::S_MWR:    w = '{gcmb_pkg::ACT_MARK_WR, gcmb_pkg::COND_ALWAYS,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_OUT};
         gcmb_pkg::S_WHITE:  w = '{gcmb_pkg::ACT_ALL_WHITE, gcmb_pkg::COND_ALWAYS,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_OUT};
         gcmb_pkg::S_BLACK:  w = '{gcmb_pkg::ACT_ALL_BLACK, gcmb_pkg::COND_ALWAYS,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_OUT};
         gcmb_pkg::S_FIRST:  w = '{gcmb_pkg::ACT_SCAN_FIRST, gcmb_pkg::COND_ALWAYS,
                                   gcmb_pkg::S_SRD, gcmb_pkg::S_SRD};
         gcmb_pkg::S_NEXT:   w = '{gcmb_pkg::ACT_SCAN_NEXT, gcmb_pkg::COND_ITER_END,
                                   gcmb_pkg::S_SNONE, gcmb_pkg::S_SRD};
         gcmb_pkg::S_SRD:    w = '{gcmb_pkg::ACT_SCAN_RD, gcmb_pkg::COND_SCAN_PAST,
                                   gcmb_pkg::S_SNONE, gcmb_pkg::S_SCHK};
         gcmb_pkg::S_SCHK:   w = '{gcmb_pkg::ACT_SCAN_CHK, gcmb_pkg::COND_FOUND,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_SRD};
         gcmb_pkg::S_SNONE:  w = '{gcmb_pkg::ACT_SCAN_NONE, gcmb_pkg::COND_ALWAYS,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_OUT};
         gcmb_pkg::S_OUT:    w = '{gcmb_pkg::ACT_OUT, gcmb_pkg::COND_RSP_BLOCKED,
                                   gcmb_pkg::S_OUT, gcmb_pkg::S_IDLE};
         default:            w = '{gcmb_pkg::ACT_NONE, gcmb_pkg::COND_ALWAYS,
                                   gcmb_pkg::S_IDLE, gcmb_pkg::S_IDLE};
      endcase
      return w;
   endfunction

   // opcode dispatch table
   function automatic gcmb_pkg::gcmb_step_type dispatch(input logic [gcmb_pkg::OP_W-1:0] op);
      gcmb_pkg::gcmb_step_type s;
      case (op)
         gcmb_pkg::OP_MARK_BLACK,
         gcmb_pkg::OP_MARK_WHITE,
         gcmb_pkg::OP_FREE_MARK:  s = gcmb_pkg::S_MRD;
         gcmb_pkg::OP_ALL_WHITE:  s = gcmb_pkg::S_WHITE;
         gcmb_pkg::OP_ARRANGE:    s = gcmb_pkg::S_BLACK;
         gcmb_pkg::OP_ITER_FIRST: s = gcmb_pkg::S_FIRST;
         gcmb_pkg::OP_ITER_NEXT:  s = gcmb_pkg::S_NEXT;
         default:                 s = gcmb_pkg::S_OUT;
      endcase
      return s;
   endfunction

   assign ctrl = rom(pc_ff);

   always_comb begin
      case (ctrl.cond)
         gcmb_pkg::COND_ALWAYS:      take = 1'b1;
         gcmb_pkg::COND_START:       take = stat.start;
         gcmb_pkg::COND_DIV_LAST:    take = stat.div_last;
         gcmb_pkg::COND_CFG_RUN:     take = stat.cfg_run;
         gcmb_pkg::COND_IDX_ERR:     take = stat.idx_err;
         gcmb_pkg::COND_ITER_END:    take = stat.iter_end;
         gcmb_pkg::COND_SCAN_PAST:   take = stat.scan_past;
         gcmb_pkg::COND_FOUND:       take = stat.found;
         gcmb_pkg::COND_RSP_BLOCKED: take = stat.rsp_blocked;
         default:                    take = 1'b0;
      endcase
   end

   always_comb begin
      if (ctrl.cond == gcmb_pkg::COND_DISPATCH) begin
         pc_in = dispatch(stat.opcode);
      end else if (take) begin
         pc_in = ctrl.jt;
      end else begin
         pc_in = ctrl.jf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= gcmb_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ design/gc_mark_bitmap_scanner.sv @@
// gc_mark_bitmap_scanner: top level, datapath registers and response register
// depends on gcmb_pkg, gcmb_divider, gcmb_mark_map, gcmb_sequencer

// Mark map of a garbage collector for one 4096-byte block cut into units of
// csr_wr_data bytes (clamped to 16..4096), one mark bit per unit. Each request
// transaction carries an opcode and a byte offset and yields exactly one
// response transaction. The block handles one transaction at a time under a
// microprogram; the unit index takes a 9-step shared divider. Then a mark
// reads its row and, unless its index is out of range, writes it back; an
// iterate reads and checks rows of 8 units one after another until one holds
// the answer or the scan passes the unit count. The result then goes into the
// output register. While the output register holds a response that is not
// taken the microprogram waits in its last step. A new request is taken while
// the previous response still waits in the output register. A unit size write
// whitens all marks and clears the free counter at once, then recomputes the
// unit count on the same divider, during which req_ready stays low.

module gc_mark_bitmap_scanner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gcmb_pkg::OP_W-1:0]         req_opcode,
   input  logic [gcmb_pkg::OFF_W-1:0]        req_offset,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gcmb_pkg::IDX_W-1:0]        rsp_unit_index,
   output logic                              rsp_index_error,
   output logic [gcmb_pkg::POS_W-1:0]        rsp_iter_pos,
   output logic                              rsp_free_list_done,
   input  logic                              csr_wr_en,
   input  logic [gcmb_pkg::SIZE_W-1:0]       csr_wr_data
);

   gcmb_pkg::gcmb_ctrl_type ctrl;
   gcmb_pkg::gcmb_stat_type stat;

   // configuration and bookkeeping
   logic [gcmb_pkg::SIZE_W-1:0]  unit_size_ff, unit_size_in;
   logic                         cfg_pend_ff, cfg_pend_in;
   logic                         cfg_run_ff, cfg_run_in;
   logic [gcmb_pkg::OP_W-1:0]    opcode_ff, opcode_in;
   logic [gcmb_pkg::POS_W-1:0]   unit_count_ff, unit_count_in;
   logic [gcmb_pkg::POS_W-1:0]   free_ff, free_in;
   logic [gcmb_pkg::POS_W-1:0]   iter_ff, iter_in;
   logic [gcmb_pkg::POS_W-1:0]   pos_ff, pos_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gcmb_pkg::IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                         rsp_err_ff, rsp_err_in;
   logic [gcmb_pkg::POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic                         rsp_done_ff, rsp_done_in;

   logic [gcmb_pkg::SIZE_W-1:0]  eff_size;
   logic                         div_load;
   logic [gcmb_pkg::DIV_W-1:0]   dividend;
   logic [gcmb_pkg::QUO_W-1:0]   quotient;
   logic                         div_last;

   logic                          clr_en, clr_val;
   logic                          rd_en, wr_en;
   logic [gcmb_pkg::ROW_AW-1:0]   rd_row, idx_row, pos_row;
   logic [gcmb_pkg::ROW_BITS-1:0] row_data, wr_data;

   logic                          is_mark_op;
   logic                          idx_err;
   logic [gcmb_pkg::ROW_BITS-1:0] cand;
   logic [gcmb_pkg::BIT_AW-1:0]   hit;
   logic [gcmb_pkg::POS_W-1:0]    unit_here;
   logic                          out_load;

   // size register clamped to the legal unit range
   always_comb begin
      if (unit_size_ff < gcmb_pkg::SIZE_W'(gcmb_pkg::MIN_UNIT)) begin
         eff_size = gcmb_pkg::SIZE_W'(gcmb_pkg::MIN_UNIT);
      end else if (unit_size_ff > gcmb_pkg::SIZE_W'(gcmb_pkg::MAX_UNIT)) begin
         eff_size = gcmb_pkg::SIZE_W'(gcmb_pkg::MAX_UNIT);
      end else begin
         eff_size = unit_size_ff;
      end
   end

   // a pending size change wins the idle slot over a waiting request
   assign req_ready = (ctrl.act == gcmb_pkg::ACT_IDLE) && !cfg_pend_ff;
   assign div_load  = (ctrl.act == gcmb_pkg::ACT_IDLE) && (cfg_pend_ff || req_valid);
   assign dividend  = cfg_pend_ff ? gcmb_pkg::DIV_W'(gcmb_pkg::BLOCK_BYTES)
                                  : gcmb_pkg::DIV_W'(req_offset);

   gcmb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .step     (ctrl.act == gcmb_pkg::ACT_DIV_STEP),
      .dividend (dividend),
      .divisor  (eff_size),
      .quotient (quotient),
      .last     (div_last)
   );

   // row and bit of the addressed unit, and of the scan position
   assign idx_row = quotient[gcmb_pkg::ROW_AW+gcmb_pkg::BIT_AW-1:gcmb_pkg::BIT_AW];
   assign pos_row = pos_ff[gcmb_pkg::ROW_AW+gcmb_pkg::BIT_AW-1:gcmb_pkg::BIT_AW];

   assign is_mark_op = (opcode_ff == gcmb_pkg::OP_MARK_BLACK) ||
                       (opcode_ff == gcmb_pkg::OP_MARK_WHITE) ||
                       (opcode_ff == gcmb_pkg::OP_FREE_MARK);
   assign idx_err    = (quotient >= unit_count_ff);

   // read-modify-write of the addressed row
   always_comb begin
      wr_data = row_data;
      wr_data[quotient[gcmb_pkg::BIT_AW-1:0]] = (opcode_ff == gcmb_pkg::OP_MARK_BLACK);
   end

   assign rd_en  = (ctrl.act == gcmb_pkg::ACT_MARK_RD) || (ctrl.act == gcmb_pkg::ACT_SCAN_RD);
   assign rd_row = (ctrl.act == gcmb_pkg::ACT_SCAN_RD) ? pos_row : idx_row;
   assign wr_en  = (ctrl.act == gcmb_pkg::ACT_MARK_WR);

   // size writes whiten, arrange blackens, all-white whitens
   assign clr_en  = csr_wr_en || (ctrl.act == gcmb_pkg::ACT_ALL_WHITE) ||
                    (ctrl.act == gcmb_pkg::ACT_ALL_BLACK);
   assign clr_val = !csr_wr_en && (ctrl.act == gcmb_pkg::ACT_ALL_BLACK);

   gcmb_mark_map u_map (
      .clock    (clock),
      .reset    (reset),
      .clr_en   (clr_en),
      .clr_val  (clr_val),
      .rd_en    (rd_en),
      .rd_row   (rd_row),
      .wr_en    (wr_en),
      .wr_row   (idx_row),
      .wr_data  (wr_data),
      .row_data (row_data)
   );

   // white units of the fetched row at or after the scan position and below the count
   always_comb begin
      for (int j = 0; j < gcmb_pkg::ROW_BITS; j++) begin
         unit_here = gcmb_pkg::POS_W'({pos_row, gcmb_pkg::BIT_AW'(j)});
         cand[j]   = !row_data[j] &&
                     (gcmb_pkg::BIT_AW'(j) >= pos_ff[gcmb_pkg::BIT_AW-1:0]) &&
                     (unit_here < unit_count_ff);
      end
   end

   // lowest white unit wins
   always_comb begin
      hit = '0;
      for (int j = gcmb_pkg::ROW_BITS - 1; j >= 0; j--) begin
         if (cand[j]) begin
            hit = gcmb_pkg::BIT_AW'(j);
         end
      end
   end

   // status back to the sequencer
   always_comb begin
      stat.start       = cfg_pend_ff || req_valid;
      stat.div_last    = div_last;
      stat.cfg_run     = cfg_run_ff;
      stat.idx_err     = idx_err;
      stat.iter_end    = (iter_ff >= unit_count_ff);
      stat.scan_past   = (pos_ff >= unit_count_ff);
      stat.found       = |cand;
      stat.rsp_blocked = rsp_valid_ff && !rsp_ready;
      stat.opcode      = opcode_ff;
   end

   gcmb_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   assign out_load = (ctrl.act == gcmb_pkg::ACT_OUT) && !(rsp_valid_ff && !rsp_ready);

   // datapath register updates, one action per microstep
   always_comb begin
      unit_size_in  = unit_size_ff;
      cfg_pend_in   = cfg_pend_ff;
      cfg_run_in    = cfg_run_ff;
      opcode_in     = opcode_ff;
      unit_count_in = unit_count_ff;
      free_in       = free_ff;
      iter_in       = iter_ff;
      pos_in        = pos_ff;

      case (ctrl.act)
         gcmb_pkg::ACT_IDLE: begin
            if (cfg_pend_ff) begin
               cfg_pend_in = 1'b0;
               cfg_run_in  = 1'b1;
            end else if (req_valid) begin
               cfg_run_in = 1'b0;
               opcode_in  = req_opcode;
            end
         end
         gcmb_pkg::ACT_UNIT_SET: begin
            if (quotient > gcmb_pkg::POS_W'(gcmb_pkg::MAX_UNITS)) begin
               unit_count_in = gcmb_pkg::POS_W'(gcmb_pkg::MAX_UNITS);
            end else begin
               unit_count_in = quotient;
            end
         end
         gcmb_pkg::ACT_MARK_WR: begin
            // free-list marks count up, saturating
            if ((opcode_ff == gcmb_pkg::OP_FREE_MARK) &&
                (free_ff != gcmb_pkg::POS_W'(gcmb_pkg::FREE_MAX))) begin
               free_in = free_ff + gcmb_pkg::POS_W'(1);
            end
         end
         gcmb_pkg::ACT_ALL_BLACK: begin
            free_in = '0;
         end
         gcmb_pkg::ACT_SCAN_FIRST: begin
            pos_in = '0;
         end
         gcmb_pkg::ACT_SCAN_NEXT: begin
            pos_in = iter_ff + gcmb_pkg::POS_W'(1);
         end
         gcmb_pkg::ACT_SCAN_CHK: begin
            if (|cand) begin
               iter_in = gcmb_pkg::POS_W'({pos_row, hit});
            end else begin
               // on to the first unit of the next row
               pos_in = gcmb_pkg::POS_W'({pos_row, gcmb_pkg::BIT_AW'(0)}) +
                        gcmb_pkg::POS_W'(gcmb_pkg::ROW_BITS);
            end
         end
         gcmb_pkg::ACT_SCAN_NONE: begin
            iter_in = unit_count_ff;
         end
         default: begin
         end
      endcase

      // a size write takes effect at once and schedules the unit count
      if (csr_wr_en) begin
         unit_size_in = csr_wr_data;
         cfg_pend_in  = 1'b1;
         free_in      = '0;
      end
   end

   // response register
   always_comb begin
      rsp_index_in = rsp_index_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = quotient[gcmb_pkg::IDX_W-1:0];
         rsp_err_in   = is_mark_op && idx_err;
         rsp_pos_in   = iter_ff;
         rsp_done_in  = (free_ff == unit_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff    <= opcode_in;
      pos_ff       <= pos_in;
      rsp_index_ff <= rsp_index_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_done_ff  <= rsp_done_in;
      if (reset) begin
         unit_size_ff  <= gcmb_pkg::SIZE_W'(gcmb_pkg::MIN_UNIT);
         cfg_pend_ff   <= 1'b0;
         cfg_run_ff    <= 1'b0;
         unit_count_ff <= gcmb_pkg::POS_W'(gcmb_pkg::MAX_UNITS);
         free_ff       <= '0;
         iter_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unit_size_ff  <= unit_size_in;
         cfg_pend_ff   <= cfg_pend_in;
         cfg_run_ff    <= cfg_run_in;
         unit_count_ff <= unit_count_in;
         free_ff       <= free_in;
         iter_ff       <= iter_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_unit_index     = rsp_index_ff;
   assign rsp_index_error    = rsp_err_ff;
   assign rsp_iter_pos       = rsp_pos_ff;
   assign rsp_free_list_done = rsp_done_ff;

endmodule

@@ design/gcmb_checker.sv @@
// gcmb_checker: port-level assertions on the scanner, bound to the top level
// depends on gcmb_pkg and gc_mark_bitmap_scanner

module gcmb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gcmb_pkg::IDX_W-1:0]     rsp_unit_index,
   input logic                           rsp_index_error,
   input logic [gcmb_pkg::POS_W-1:0]     rsp_iter_pos,
   input logic                           rsp_free_list_done,
   input logic                           csr_wr_en
);

   logic [1:0] open_ff, open_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // transactions taken whose response is not yet delivered
   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_acc) begin
         open_in = open_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 2'd0))
      else $error("response without an open transaction");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      (open_ff == 2'd2) |-> !req_ready)
      else $error("third transaction taken before a response left");

   a_size_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_ready)
      else $error("request taken before the unit count was recomputed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_unit_index) &&
         $stable(rsp_index_error) && $stable(rsp_iter_pos) && $stable(rsp_free_list_done)))
      else $error("stalled response changed");

endmodule

bind gc_mark_bitmap_scanner gcmb_checker u_gcmb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_unit_index     (rsp_unit_index),
   .rsp_index_error    (rsp_index_error),
   .rsp_iter_pos       (rsp_iter_pos),
   .rsp_free_list_done (rsp_free_list_done),
   .csr_wr_en          (csr_wr_en)
);
